/* rtl/rc7_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rc7_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned AccW     = 40;
  localparam int unsigned NTaps    = 7;
  localparam int unsigned WinDepth = NTaps - 1;
  localparam int unsigned ProdW    = 2 * SampleW;
  // Seven products need three more bits than one product.
  localparam int unsigned DotW     = ProdW + 3;
  localparam int unsigned SumW     = ((DotW > AccW) ? DotW : AccW) + 1;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);
  localparam int unsigned CfgIdxW  = $clog2(NTaps + 1);

  localparam logic [FillW-1:0] FillFull = FillW'(WinDepth);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic signed [DotW-1:0]    dot_t;

  typedef struct packed {
    sample_t    sample;
    acc_t       partial_sum;
    logic       row_start;
  } in_item_t;

  typedef struct packed {
    acc_t       sum;
    logic       saturated;
  } out_item_t;

  // Work in flight through the cell row.
  typedef struct packed {
    logic                     vld;
    dot_t                     dot;
    acc_t                     psum;
    sample_t [NTaps-1:0]      smp;
  } cell_t;

endpackage

`default_nettype wire

/* rtl/rc7_window.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc7_window (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire rc7_pkg::in_item_t item_i,
  output rc7_pkg::cell_t         head_o
);
  import rc7_pkg::*;

  sample_t [WinDepth-1:0] win_q, win_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic [FillW-1:0]       fill_eff;
  logic                   produce;

  assign fill_eff = item_i.row_start ? '0 : fill_q;
  assign produce  = (fill_eff == FillFull);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept_i) begin
      // Shift always: after six samples of a row the window holds exactly them.
      win_d  = {item_i.sample, win_q[WinDepth-1:1]};
      fill_d = produce ? FillFull : fill_eff + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_comb begin
    head_o.vld  = accept_i && produce;
    head_o.dot  = '0;
    head_o.psum = item_i.partial_sum;
    head_o.smp  = {item_i.sample, win_q};
  end

endmodule

`default_nettype wire

/* rtl/rc7_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc7_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire rc7_pkg::sample_t tap_i,
  input  wire rc7_pkg::cell_t  prev_i,
  output rc7_pkg::cell_t       next_o
);
  import rc7_pkg::*;

  cell_t                     cell_q, cell_d;
  logic signed [ProdW-1:0]   prod;

  assign prod = prev_i.smp[0] * tap_i;

  always_comb begin
    cell_d.vld  = prev_i.vld;
    cell_d.dot  = prev_i.dot + DotW'(prod);
    cell_d.psum = prev_i.psum;
    // Hand the remaining samples on, next one at the bottom.
    cell_d.smp  = {sample_t'(0), prev_i.smp[NTaps-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign next_o = cell_q;

endmodule

`default_nettype wire

/* rtl/rc7_sat.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc7_sat (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire rc7_pkg::cell_t     last_i,
  output logic                    out_valid_o,
  output rc7_pkg::out_item_t      out_data_o
);
  import rc7_pkg::*;

  logic signed [SumW-1:0] total;
  logic                   ovf;
  logic                   valid_q;
  out_item_t              data_q, data_d;

  assign total = SumW'(last_i.psum) + SumW'(last_i.dot);
  // Overflow when the bits above the accumulator sign are not all sign copies.
  assign ovf   = (total[SumW-1:AccW-1] != {(SumW-AccW+1){total[SumW-1]}});

  always_comb begin
    data_d.saturated = ovf;
    if (!ovf) begin
      data_d.sum = total[AccW-1:0];
    end else if (total[SumW-1]) begin
      data_d.sum = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      data_d.sum = {1'b0, {(AccW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= last_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/row_conv_1x7_accumulate.sv */
// Pipeline: an accepted sample is captured by the first tap cell at the accepting edge;
// six more cells and the saturating output register follow.
// Throughput: one sample per cycle; the whole cell row advances together and
// holds while a result waits at the output.
// Reset: asynchronous, active low; clears taps, fill count and all valid bits.
`timescale 1ns / 1ps
`default_nettype none

module row_conv_1x7_accumulate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rc7_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rc7_pkg::SampleW-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rc7_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rc7_pkg::out_item_t                 out_data_o
);
  import rc7_pkg::*;

  sample_t [NTaps-1:0] tap_q;
  cell_t   [NTaps:0]   chain;
  logic                adv;
  logic                accept;

  // Move the whole row unless a result is stuck at the output.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NTaps))) begin
      tap_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  rc7_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .head_o   (chain[0])
  );

  for (genvar k = 0; k < NTaps; k++) begin : g_cell
    rc7_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tap_i  (tap_q[k]),
      .prev_i (chain[k]),
      .next_o (chain[k+1])
    );
  end

  rc7_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .last_i      (chain[NTaps]),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_row_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.row_start) |=> !chain[1].vld)
    else $error("first sample of a row produced a result");

  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      ((out_data_o.sum == {1'b1, {(AccW-1){1'b0}}}) ||
       (out_data_o.sum == {1'b0, {(AccW-1){1'b1}}})))
    else $error("saturated result not at accumulator limit");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && chain[NTaps].vld) |=> chain[NTaps].vld)
    else $error("last cell lost a transaction while stalled");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rc7_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TAP0, REG_TAP1, REG_TAP2, REG_TAP3, REG_TAP4, REG_TAP5, REG_TAP6, REG_UNUSED
  } reg_idx_e;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    reg_idx_e           idx;
    logic [SampleW-1:0] cfg_val;
    in_item_t           item;
    bit                 typed;
    out_item_t          want;
  } dir_row_t;

  localparam longint  AccMax      = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint  AccMin      = -AccMax - 1;
  localparam sample_t SmpMax      = sample_t'({1'b0, {(SampleW - 1){1'b1}}});
  localparam sample_t SmpMin      = sample_t'({1'b1, {(SampleW - 1){1'b0}}});
  localparam int      DrainCycles = 12;
  localparam int      CycleLimit  = 400000;
  localparam int      PhaseItems  = 95;
  localparam int      NumPhases   = 7;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [SampleW-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;

  sample_t   tap_q [NTaps];
  sample_t   win_q [WinDepth];
  int        fill_q = 0;
  out_item_t sum_q [$];
  dir_row_t  dir_tbl [$];
  int        errors = 0;
  int        cycles = 0;
  bit        in_burst = 1'b0;

  row_conv_1x7_accumulate uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Column sum for one accepted sample; returns 1 when a column completes.
  function automatic bit conv_column(input in_item_t it, output out_item_t res);
    longint dot;
    longint total;
    res = '0;
    if (it.row_start) fill_q = 0;
    if (fill_q < WinDepth) begin
      win_q[fill_q] = it.sample;
      fill_q++;
      return 1'b0;
    end
    dot = longint'(it.sample) * longint'(tap_q[NTaps - 1]);
    for (int i = 0; i < WinDepth; i++) dot += longint'(win_q[i]) * longint'(tap_q[i]);
    total = longint'(it.partial_sum) + dot;
    res.saturated = (total > AccMax) || (total < AccMin);
    if (total > AccMax) total = AccMax;
    else if (total < AccMin) total = AccMin;
    res.sum = acc_t'(total);
    for (int i = 0; i + 1 < WinDepth; i++) win_q[i] = win_q[i + 1];
    win_q[WinDepth - 1] = it.sample;
    return 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SmpMin;
      1: return SmpMax;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Bias toward the accumulator rails so the clip path gets exercised.
  function automatic acc_t pick_psum();
    case ($urandom_range(0, 5))
      0: return acc_t'(AccMax - 4 * longint'($urandom));
      1: return acc_t'(AccMin + 4 * longint'($urandom));
      default: return acc_t'({$urandom, $urandom});
    endcase
  endfunction

  function automatic dir_row_t row_item(input sample_t s, input acc_t p, input logic rs);
    dir_row_t r;
    r = '{kind: ROW_ITEM, idx: REG_TAP0, cfg_val: '0, item: '0, typed: 1'b0, want: '0};
    r.item.sample      = s;
    r.item.partial_sum = p;
    r.item.row_start   = rs;
    return r;
  endfunction

  function automatic dir_row_t row_check(input sample_t s, input acc_t p, input logic rs,
                                         input acc_t sum, input logic sat);
    dir_row_t r;
    r = row_item(s, p, rs);
    r.typed          = 1'b1;
    r.want.sum       = sum;
    r.want.saturated = sat;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input reg_idx_e idx, input sample_t v);
    dir_row_t r;
    r = row_item('0, '0, 1'b0);
    r.kind    = ROW_CFG;
    r.idx     = idx;
    r.cfg_val = v;
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 100) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [SampleW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx != REG_UNUSED) tap_q[idx] = sample_t'(val);
  endtask

  task automatic send_sample(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t res;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (conv_column(it, res)) sum_q.push_back(typed ? want : res);
  endtask

  // Drain: warm-up samples yield nothing, so wait out the pipeline too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : mon
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sum_q.size() == 0) begin
        report($sformatf("unexpected transaction, sum %0d", out_data_o.sum));
      end else begin
        want = sum_q.pop_front();
        if (out_data_o.sum !== want.sum)
          report($sformatf("sum got %0d want %0d", out_data_o.sum, want.sum));
        if (out_data_o.saturated !== want.saturated)
          report($sformatf("saturated got %0b want %0b", out_data_o.saturated,
                           want.saturated));
      end
    end
  end

  initial begin : stall_drv
    int n;
    int quiet;
    quiet = 0;
    forever begin
      if (quiet > 0) begin
        n = 0;
        quiet--;
      end else if ($urandom_range(0, 9) == 0) begin
        n = 0;
        quiet = $urandom_range(5, 30);
      end else begin
        n = $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stim
    bit       pending;
    bit       noisy;
    int       sent;
    int       len;
    in_item_t it;

    pending = 1'b0;
    foreach (tap_q[i]) tap_q[i] = '0;
    foreach (win_q[i]) win_q[i] = '0;

    // Taps at reset value: sum is just the partial sum. No row_start at first.
    dir_tbl.push_back(row_item(SmpMax, acc_t'(AccMax), 1'b0));
    repeat (5) dir_tbl.push_back(row_item(SmpMin, '0, 1'b0));
    dir_tbl.push_back(row_check('0, acc_t'(AccMax), 1'b0, acc_t'(AccMax), 1'b0));
    dir_tbl.push_back(row_check(SmpMax, acc_t'(AccMin), 1'b0, acc_t'(AccMin), 1'b0));
    // All taps at the negative rail; unused index must leave them alone.
    for (int r = REG_TAP0; r <= REG_TAP6; r++) dir_tbl.push_back(row_cfg(reg_idx_e'(r), SmpMin));
    dir_tbl.push_back(row_cfg(REG_UNUSED, SmpMax));
    dir_tbl.push_back(row_item(SmpMin, acc_t'(AccMin), 1'b1));
    repeat (5) dir_tbl.push_back(row_item(SmpMin, '0, 1'b0));
    dir_tbl.push_back(row_check(SmpMin, acc_t'(AccMax), 1'b0, acc_t'(AccMax), 1'b1));
    dir_tbl.push_back(row_item(SmpMax, acc_t'(AccMin), 1'b0));
    // Positive taps, negative samples: clip low. Restart the row after two samples.
    for (int r = REG_TAP0; r <= REG_TAP6; r++) dir_tbl.push_back(row_cfg(reg_idx_e'(r), SmpMax));
    dir_tbl.push_back(row_item(SmpMin, '0, 1'b1));
    dir_tbl.push_back(row_item(SmpMin, '0, 1'b0));
    dir_tbl.push_back(row_item(SmpMin, '0, 1'b1));
    repeat (5) dir_tbl.push_back(row_item(SmpMin, '0, 1'b0));
    dir_tbl.push_back(row_check(SmpMin, acc_t'(AccMin), 1'b0, acc_t'(AccMin), 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_CFG) begin
        if (pending) begin
          settle();
          pending = 1'b0;
        end
        write_reg(dir_tbl[k].idx, dir_tbl[k].cfg_val);
      end else begin
        send_sample(dir_tbl[k].item, dir_tbl[k].typed, dir_tbl[k].want);
        pending = 1'b1;
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      for (int r = REG_TAP0; r <= REG_TAP6; r++)
        write_reg(reg_idx_e'(r), (ph == 0) ? SmpMax : (ph == 1) ? SmpMin : pick_sample());
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, SampleW'($urandom));
      sent = 0;
      while (sent < PhaseItems) begin
        in_burst = ($urandom_range(0, 3) == 0);
        noisy    = ($urandom_range(0, 4) == 0);
        len      = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        for (int j = 0; j < len; j++) begin
          it.sample      = pick_sample();
          it.partial_sum = pick_psum();
          it.row_start   = noisy ? ($urandom_range(0, 5) == 0) : (j == 0);
          send_sample(it, 1'b0, '0);
        end
        sent += len;
      end
    end

    settle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
